/* design/bstc_pkg.sv */
// ----------------------------------------------------------------------------
// bstc_pkg
// Shared types, byte constants and byte-class helpers for the token classifier.
// ----------------------------------------------------------------------------
package bstc_pkg;

  localparam int unsigned MaxTokenLenDefault = 255;
  localparam int unsigned ResultQueueDepth   = 4;

  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [15:0] POS_MAX   = 16'hFFFF;

  typedef enum logic [2:0] {
    TOK_STRING  = 3'd0,
    TOK_INTEGER = 3'd1,
    TOK_IDENT   = 3'd2,
    TOK_SYMBOL  = 3'd3,
    TOK_UNKNOWN = 3'd4
  } tok_type_t;

  typedef enum logic [1:0] {
    QW_NONE     = 2'd0,
    QW_MISMATCH = 2'd1,
    QW_UNTERM   = 2'd2
  } quote_warn_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } bstc_in_t;

  typedef struct packed {
    tok_type_t   token_type;
    logic [7:0]  token_length;
    logic        too_long;
    logic [15:0] start_row;
    logic [15:0] start_col;
    quote_warn_t quote_warning;
    logic        last_of_run;
  } bstc_out_t;

  typedef struct packed {
    tok_type_t   token_type;
    quote_warn_t quote_warning;
  } bstc_class_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic quote_char(input logic [7:0] b);
    return (b == CH_DQUOTE) || (b == CH_SQUOTE);
  endfunction

  function automatic logic sym_char(input logic [7:0] b);
    logic p;
    p = (b >= 8'd33 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
        (b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126);
    return p && !quote_char(b);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'd48) && (b <= 8'd57);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122);
  endfunction

  // Class a token from its first and last bytes; multi flags two or more bytes.
  function automatic bstc_class_t classify(input logic [7:0] first,
                                           input logic [7:0] last,
                                           input logic       multi);
    bstc_class_t c;
    c.token_type    = TOK_UNKNOWN;
    c.quote_warning = QW_NONE;
    if (sym_char(first)) begin
      c.token_type = TOK_SYMBOL;
    end else if (quote_char(first)) begin
      if (multi && last == first) begin
        c.token_type = TOK_STRING;
      end else if (quote_char(last) && last != first) begin
        c.quote_warning = QW_MISMATCH;
      end else begin
        c.quote_warning = QW_UNTERM;
      end
    end else if (is_digit(first)) begin
      c.token_type = TOK_INTEGER;
    end else if (is_alpha(first) && !quote_char(last)) begin
      c.token_type = TOK_IDENT;
    end
    return c;
  endfunction

endpackage

/* design/byte_stream_token_classifier_core.sv */
// ----------------------------------------------------------------------------
// byte_stream_token_classifier_core
// Splits a byte stream into tokens and classes each one by its edge bytes.
// ----------------------------------------------------------------------------
// Result beats are written into the queue as their closing byte is accepted.
// Throughput: one input beat per cycle; a token-closing symbol byte makes two
//   result beats. A four-entry result queue drains one per cycle unless
//   out_stall holds it, and stalls input when fewer than two slots are free.
// Reset: synchronous, active low; clears the queue, the token state and the
//   position counters (row and column back to 1).
module byte_stream_token_classifier_core
  import bstc_pkg::*;
#(
  parameter int unsigned MAX_TOKEN_LEN = MaxTokenLenDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  bstc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output bstc_out_t out_data
);

  // Length counter holds MAX_TOKEN_LEN itself.
  localparam int unsigned LEN_W = $clog2(MAX_TOKEN_LEN + 1);
  localparam int unsigned QD    = ResultQueueDepth;
  localparam int unsigned PTR_W = $clog2(QD);
  localparam int unsigned CNT_W = $clog2(QD + 1);

  // Token and position state.
  logic             in_token_r, in_token_nxt;
  logic [7:0]       first_byte_r, first_byte_nxt;
  logic [7:0]       final_byte_r, final_byte_nxt;
  logic [LEN_W-1:0] pend_len_r, pend_len_nxt;
  logic             len_over_r, len_over_nxt;
  logic [15:0]      cur_row_r, cur_row_nxt;
  logic [15:0]      cur_col_r, cur_col_nxt;
  logic [15:0]      tok_row_r, tok_row_nxt;
  logic [15:0]      tok_col_r, tok_col_nxt;

  // Result queue.
  bstc_out_t        queue_r [QD];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic        accept;
  logic        pop;
  logic [7:0]  b;
  logic        b_punct;
  logic        b_space;
  bstc_class_t cls;
  bstc_out_t   flush_res;
  bstc_out_t   sym_res;
  bstc_out_t   push0, push1;
  logic [1:0]  n_push;

  // Take a byte only while two queue slots are free.
  assign in_stall  = (count_r > CNT_W'(QD - 2));
  assign accept    = in_valid && !in_stall;
  assign out_valid = (count_r != '0);
  assign out_data  = queue_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  assign b       = in_data.data_byte;
  assign b_punct = sym_char(b);
  assign b_space = is_space(b);
  assign cls     = classify(first_byte_r, final_byte_r, pend_len_r > LEN_W'(1));

  // Result that closes the pending token; last of run unless a symbol follows.
  always_comb begin
    flush_res.token_type    = cls.token_type;
    flush_res.token_length  = 8'(pend_len_r);
    flush_res.too_long      = len_over_r;
    flush_res.start_row     = tok_row_r;
    flush_res.start_col     = tok_col_r;
    flush_res.quote_warning = cls.quote_warning;
    flush_res.last_of_run   = !b_punct;

    sym_res.token_type    = TOK_SYMBOL;
    sym_res.token_length  = 8'd1;
    sym_res.too_long      = 1'b0;
    sym_res.start_row     = cur_row_r;
    sym_res.start_col     = cur_col_r;
    sym_res.quote_warning = QW_NONE;
    sym_res.last_of_run   = 1'b1;
  end

  // Next state of the token tracker and what goes into the queue.
  always_comb begin
    in_token_nxt   = in_token_r;
    first_byte_nxt = first_byte_r;
    final_byte_nxt = final_byte_r;
    pend_len_nxt   = pend_len_r;
    len_over_nxt   = len_over_r;
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    tok_row_nxt    = tok_row_r;
    tok_col_nxt    = tok_col_r;
    push0          = flush_res;
    push1          = sym_res;
    n_push         = 2'd0;

    if (accept) begin
      if (in_data.end_of_input) begin
        // Drop any pending token and return the token and position state to reset.
        in_token_nxt   = 1'b0;
        first_byte_nxt = '0;
        final_byte_nxt = '0;
        pend_len_nxt   = '0;
        len_over_nxt   = 1'b0;
        cur_row_nxt    = 16'd1;
        cur_col_nxt    = 16'd1;
        tok_row_nxt    = 16'd1;
        tok_col_nxt    = 16'd1;
      end else begin
        // Advance the position; newline starts a new row.
        if (b == CH_NEWLINE) begin
          if (cur_row_r != POS_MAX) begin
            cur_row_nxt = cur_row_r + 16'd1;
          end
          cur_col_nxt = 16'd1;
        end else if (cur_col_r != POS_MAX) begin
          cur_col_nxt = cur_col_r + 16'd1;
        end

        if (b_punct || b_space) begin
          // Close the pending token, then emit the symbol for punctuation.
          if (in_token_r) begin
            in_token_nxt = 1'b0;
            pend_len_nxt = '0;
            len_over_nxt = 1'b0;
            push0        = flush_res;
            n_push       = b_punct ? 2'd2 : 2'd1;
          end else if (b_punct) begin
            push0  = sym_res;
            n_push = 2'd1;
          end
        end else begin
          // Extend or open a token; length saturates and flags overflow.
          if (!in_token_r) begin
            in_token_nxt   = 1'b1;
            first_byte_nxt = b;
            tok_row_nxt    = cur_row_r;
            tok_col_nxt    = cur_col_r;
            pend_len_nxt   = LEN_W'(1);
            len_over_nxt   = 1'b0;
          end else if (pend_len_r < LEN_W'(MAX_TOKEN_LEN)) begin
            pend_len_nxt = pend_len_r + LEN_W'(1);
          end else begin
            len_over_nxt = 1'b1;
          end
          final_byte_nxt = b;
        end
      end
    end

    wr_ptr_nxt = wr_ptr_r + PTR_W'(n_push);
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(n_push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_token_r   <= 1'b0;
      first_byte_r <= '0;
      final_byte_r <= '0;
      pend_len_r   <= '0;
      len_over_r   <= 1'b0;
      cur_row_r    <= 16'd1;
      cur_col_r    <= 16'd1;
      tok_row_r    <= 16'd1;
      tok_col_r    <= 16'd1;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      count_r      <= '0;
    end else begin
      in_token_r   <= in_token_nxt;
      first_byte_r <= first_byte_nxt;
      final_byte_r <= final_byte_nxt;
      pend_len_r   <= pend_len_nxt;
      len_over_r   <= len_over_nxt;
      cur_row_r    <= cur_row_nxt;
      cur_col_r    <= cur_col_nxt;
      tok_row_r    <= tok_row_nxt;
      tok_col_r    <= tok_col_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      count_r      <= count_nxt;
    end
  end

  // Queue payload needs no reset; only slots covered by the count are read.
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      queue_r[wr_ptr_r] <= push0;
    end
    if (n_push == 2'd2) begin
      queue_r[wr_ptr_r + PTR_W'(1)] <= push1;
    end
  end

endmodule

/* design/bstc_checker.sv */
// ----------------------------------------------------------------------------
// bstc_checker
// Port-level checks for the token classifier, bound to the core module.
// ----------------------------------------------------------------------------
module bstc_checker
  import bstc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input bstc_in_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input bstc_out_t out_data
);

  // A stalled input beat holds until taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input beat changed under stall");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed under stall");

  // A closing token that is not last is followed at once by its symbol.
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_of_run |=>
      out_valid && out_data.last_of_run && out_data.token_type == TOK_SYMBOL)
    else $error("token pair split");

  // Symbols are single bytes without flags.
  a_symbol: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.token_type == TOK_SYMBOL |->
      out_data.token_length == 8'd1 && !out_data.too_long &&
      out_data.quote_warning == QW_NONE)
    else $error("malformed symbol result");

  // Quote warnings come only with unknown tokens; positions are 1-based.
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.quote_warning == QW_NONE ||
                   out_data.token_type == TOK_UNKNOWN) &&
                  out_data.start_row != 16'd0 && out_data.start_col != 16'd0)
    else $error("inconsistent result fields");

endmodule

bind byte_stream_token_classifier_core bstc_checker u_bstc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte stream token classifier. Bytes go in one
// beat at a time, a lexer model in the bench predicts every token beat, and a
// monitor compares each accepted result beat field by field against the
// oldest prediction. Directed tests cover the classes, the length cap, input
// stall and positions; random streams of mostly well-formed tokens follow.
// ----------------------------------------------------------------------------
module tb_top;
  import bstc_pkg::*;

  localparam int unsigned TOKEN_CAP = MaxTokenLenDefault;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  bstc_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  bstc_out_t out_data;

  // Bench knobs: idle percentages for each side and a receiver hold-off count.
  int src_idle_pct = 0;
  int dst_idle_pct = 0;
  int hold_cycles  = 0;
  int errors       = 0;
  int beats_sent   = 0;

  // Token beats predicted but not yet seen on the output, oldest first.
  bstc_out_t tokens_due[$];

  // Lexer model state: the token being collected and the running position.
  logic        lx_in_tok;
  logic [7:0]  lx_first;
  logic [7:0]  lx_last;
  logic [7:0]  lx_len;
  logic        lx_over;
  logic [15:0] lx_row;
  logic [15:0] lx_col;
  logic [15:0] lx_tok_row;
  logic [15:0] lx_tok_col;

  byte_stream_token_classifier_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Byte classes, written out by range.
  // --------------------------------------------------------------------------
  function automatic logic ws_byte(input logic [7:0] b);
    return b inside {8'd32, [8'd9:8'd13]};
  endfunction

  function automatic logic quote_byte(input logic [7:0] b);
    return b inside {CH_DQUOTE, CH_SQUOTE};
  endfunction

  // Printable punctuation, with both quotes left out since they build tokens.
  function automatic logic sym_byte(input logic [7:0] b);
    return !quote_byte(b) &&
           (b inside {[8'd33:8'd47], [8'd58:8'd64], [8'd91:8'd96], [8'd123:8'd126]});
  endfunction

  function automatic logic digit_byte(input logic [7:0] b);
    return b inside {[8'd48:8'd57]};
  endfunction

  function automatic logic letter_byte(input logic [7:0] b);
    return b inside {[8'd65:8'd90], [8'd97:8'd122]};
  endfunction

  // Class a token from its edge bytes. A quote opener needs a matching quote
  // as the last byte and at least two bytes to be a string; a lone quote is
  // unterminated since its last byte is its first.
  function automatic void grade_token(input logic [7:0] first, input logic [7:0] last,
                                      input logic [7:0] len, output tok_type_t kind,
                                      output quote_warn_t warn);
    kind = TOK_UNKNOWN;
    warn = QW_NONE;
    if (sym_byte(first)) begin
      kind = TOK_SYMBOL;
    end else if (quote_byte(first)) begin
      if (len >= 8'd2 && last == first) begin
        kind = TOK_STRING;
      end else if (quote_byte(last) && last != first) begin
        warn = QW_MISMATCH;
      end else begin
        warn = QW_UNTERM;
      end
    end else if (digit_byte(first)) begin
      kind = TOK_INTEGER;
    end else if (letter_byte(first) && !quote_byte(last)) begin
      kind = TOK_IDENT;
    end
  endfunction

  function automatic void clear_lexer();
    lx_in_tok  = 1'b0;
    lx_first   = '0;
    lx_last    = '0;
    lx_len     = '0;
    lx_over    = 1'b0;
    lx_row     = 16'd1;
    lx_col     = 16'd1;
    lx_tok_row = 16'd1;
    lx_tok_col = 16'd1;
  endfunction

  // --------------------------------------------------------------------------
  // Advance the lexer model by one accepted beat and queue the token beats
  // that it closes: at most the pending token and then a symbol.
  // --------------------------------------------------------------------------
  function automatic void lex_byte(input bstc_in_t beat);
    logic [7:0]  b;
    logic [15:0] here_row;
    logic [15:0] here_col;
    logic        have_held;
    bstc_out_t   held;
    bstc_out_t   sym;
    tok_type_t   kind;
    quote_warn_t warn;
    b = beat.data_byte;
    have_held = 1'b0;
    held = '0;
    // End of input drops whatever is pending and rewinds the position.
    if (beat.end_of_input) begin
      clear_lexer();
      return;
    end
    here_row = lx_row;
    here_col = lx_col;
    if (b == CH_NEWLINE) begin
      if (lx_row != POS_MAX) lx_row = lx_row + 16'd1;
      lx_col = 16'd1;
    end else if (lx_col != POS_MAX) begin
      lx_col = lx_col + 16'd1;
    end
    // Whitespace and punctuation both close the pending token.
    if ((sym_byte(b) || ws_byte(b)) && lx_in_tok) begin
      grade_token(lx_first, lx_last, lx_len, kind, warn);
      held.token_type    = kind;
      held.token_length  = lx_len;
      held.too_long      = lx_over;
      held.start_row     = lx_tok_row;
      held.start_col     = lx_tok_col;
      held.quote_warning = warn;
      held.last_of_run   = 1'b0;
      have_held = 1'b1;
      lx_in_tok = 1'b0;
      lx_len    = '0;
      lx_over   = 1'b0;
    end
    if (sym_byte(b)) begin
      if (have_held) tokens_due.push_back(held);
      sym.token_type    = TOK_SYMBOL;
      sym.token_length  = 8'd1;
      sym.too_long      = 1'b0;
      sym.start_row     = here_row;
      sym.start_col     = here_col;
      sym.quote_warning = QW_NONE;
      sym.last_of_run   = 1'b1;
      tokens_due.push_back(sym);
    end else if (ws_byte(b)) begin
      if (have_held) begin
        held.last_of_run = 1'b1;
        tokens_due.push_back(held);
      end
    end else begin
      // Any other byte extends the token; past the cap only the last byte moves.
      if (!lx_in_tok) begin
        lx_in_tok  = 1'b1;
        lx_first   = b;
        lx_tok_row = here_row;
        lx_tok_col = here_col;
        lx_len     = 8'd1;
        lx_over    = 1'b0;
      end else if (int'(lx_len) < TOKEN_CAP) begin
        lx_len = lx_len + 8'd1;
      end else begin
        lx_over = 1'b1;
      end
      lx_last = b;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus side. Drive at the falling edge, look for acceptance at the
  // rising edge. in_valid stays high after a beat so back-to-back beats need
  // no gap; anything that waits must drop it first through go_quiet.
  // --------------------------------------------------------------------------
  task automatic send_beat(input logic [7:0] b, input logic eoi);
    bstc_in_t beat;
    beat.data_byte    = b;
    beat.end_of_input = eoi;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    lex_byte(beat);
    beats_sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_beat(s[i], 1'b0);
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Stop offering bytes until every predicted token beat has come out.
  task automatic wait_drain();
    go_quiet();
    while (tokens_due.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: random stall, or a solid hold-off while hold_cycles runs.
  // --------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < dst_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every accepted result beat must match the oldest prediction.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_beats
    bstc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (tokens_due.size() == 0) begin
        errors++;
        $display("%0t ns: result beat with nothing predicted, expected none, actual %h",
                 $time, out_data);
      end else begin
        want = tokens_due.pop_front();
        check_field("token_type", int'(want.token_type), int'(out_data.token_type));
        check_field("token_length", int'(want.token_length),
                    int'(out_data.token_length));
        check_field("too_long", int'(want.too_long), int'(out_data.too_long));
        check_field("start_row", int'(want.start_row), int'(out_data.start_row));
        check_field("start_col", int'(want.start_col), int'(out_data.start_col));
        check_field("quote_warning", int'(want.quote_warning),
                    int'(out_data.quote_warning));
        check_field("last_of_run", int'(want.last_of_run), int'(out_data.last_of_run));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Random byte pickers.
  // --------------------------------------------------------------------------
  function automatic logic [7:0] pick_letter();
    return ($urandom_range(1) != 0) ? 8'($urandom_range(65, 90))
                                    : 8'($urandom_range(97, 122));
  endfunction

  function automatic logic [7:0] pick_alnum();
    return ($urandom_range(3) == 0) ? 8'($urandom_range(48, 57)) : pick_letter();
  endfunction

  function automatic logic [7:0] pick_quote();
    return ($urandom_range(1) != 0) ? CH_DQUOTE : CH_SQUOTE;
  endfunction

  function automatic logic [7:0] pick_symbol();
    logic [7:0] b;
    do b = 8'($urandom_range(33, 126)); while (!sym_byte(b));
    return b;
  endfunction

  // Half spaces and newlines so the row counter moves, half tab to CR.
  function automatic logic [7:0] pick_space();
    case ($urandom_range(3))
      0:       return 8'd32;
      1:       return CH_NEWLINE;
      default: return 8'($urandom_range(9, 13));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // One short case per class and per quote outcome, plus the drop at end of
  // input and whitespace with nothing pending.
  task automatic test_token_classes();
    send_text("a;");            // identifier closed by a symbol: two beats
    send_text(" 7\n");          // idle space, then an integer ended by newline
    send_text("\"h\"!");        // string literal, then a symbol
    send_text("'q\" ");         // closing quote of the other kind
    send_text("'x,");           // no closing quote at all
    send_text("' ");            // lone quote byte
    send_text("x' ");           // letter then quote: unknown, no warning
    send_beat(8'h80, 1'b0);     // high and control bytes make an unknown token
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    send_text(" ab");
    send_beat(8'h5A, 1'b1);     // end of input drops "ab" and rewinds position
    send_beat(8'hA5, 1'b1);
    send_text("q\t");
    wait_drain();
  endtask

  // A quoted token that runs one byte past the length cap. The closing quote
  // lands after saturation and must still make a string.
  task automatic test_length_limit();
    send_beat(CH_DQUOTE, 1'b0);
    repeat (TOKEN_CAP - 1) send_beat("s", 1'b0);
    send_beat(CH_DQUOTE, 1'b0);
    send_beat(CH_NEWLINE, 1'b0);
    wait_drain();
  endtask

  // Hold the receiver off while bytes keep coming so the result queue fills
  // and the block has to stall its input.
  task automatic test_backpressure();
    wait_drain();
    hold_cycles = 60;
    repeat (20) send_text("ab;");
    wait_drain();
  endtask

  // Check the positions reported after blank lines, indents and tabs.
  task automatic test_positions();
    send_text("\n\n  xy\n\tz;");
    send_beat(8'h00, 1'b1);
    wait_drain();
  endtask

  // Random streams of mostly well-formed tokens with some noise and the odd
  // end of input.
  task automatic test_random_stream(input int beats);
    int stop_at;
    int pick;
    logic [7:0] q;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        send_beat(pick_letter(), 1'b0);
        repeat ($urandom_range(7)) send_beat(pick_alnum(), 1'b0);
        if ($urandom_range(9) == 0) send_beat(pick_quote(), 1'b0);
      end else if (pick < 40) begin
        send_beat(8'($urandom_range(48, 57)), 1'b0);
        repeat ($urandom_range(5)) send_beat(pick_alnum(), 1'b0);
      end else if (pick < 55) begin
        q = pick_quote();
        send_beat(q, 1'b0);
        repeat ($urandom_range(6)) send_beat(pick_alnum(), 1'b0);
        case ($urandom_range(7))
          0, 1:    send_beat((q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE, 1'b0);
          2, 3:    ;  // leave it open
          default: send_beat(q, 1'b0);
        endcase
      end else if (pick < 70) begin
        send_beat(pick_symbol(), 1'b0);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 3)) send_beat(pick_space(), 1'b0);
      end else if (pick < 97) begin
        repeat ($urandom_range(1, 3)) send_beat(8'($urandom_range(255)), 1'b0);
      end else begin
        send_beat(8'($urandom_range(255)), 1'b1);
      end
    end
    wait_drain();
  endtask

  // --------------------------------------------------------------------------
  // Sequence: reset once, then three idle phases.
  // --------------------------------------------------------------------------
  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    clear_lexer();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Sender mostly busy, receiver mostly stalled.
    src_idle_pct = 6;
    dst_idle_pct = 71;
    test_token_classes();
    test_length_limit();
    test_random_stream(110);

    // Sender mostly idle, receiver mostly ready.
    src_idle_pct = 71;
    dst_idle_pct = 6;
    test_random_stream(110);

    // No idling on either side.
    src_idle_pct = 0;
    dst_idle_pct = 0;
    test_backpressure();
    test_positions();
    test_random_stream(110);

    wait_drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && tokens_due.size() == 0) begin
      $display("byte_stream_token_classifier_core: match");
    end else begin
      $display("byte_stream_token_classifier_core: mismatch");
    end
    $finish;
  end

  // Watchdog: well past the slowest legal run.
  initial begin
    #3_000_000;
    $display("byte_stream_token_classifier_core: mismatch");
    $finish;
  end

endmodule
